/* rtl/triangle_scanline_span_top_defines.svh */
// assertion macros shared by the span block modules
// no dependencies; taken in by `include where assertions are written
`ifndef TRIANGLE_SCANLINE_SPAN_TOP_DEFINES_SVH
`define TRIANGLE_SCANLINE_SPAN_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TSP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("span block check failed");

// next-cycle implication, checked out of reset
`define TSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("span block check failed");

`endif

/* rtl/tsp_pkg.sv */
// shared widths, register codes and queue item type of the span block
// no dependencies
package tsp_pkg;

  localparam int COORD_BITS = 14;
  localparam int ROW_BITS   = 13;
  localparam int REG_BITS   = 14;
  localparam int COLR_BITS  = 8;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int CMP_BITS   = ((COORD_BITS > ROW_BITS) ? COORD_BITS : ROW_BITS) + 2;
  localparam int NUM_BITS   = 2 * COORD_BITS;
  localparam int QUO_BITS   = COORD_BITS;
  localparam int COL_BITS   = COORD_BITS + 2;
  localparam int WIDE_BITS  = ((COL_BITS > REG_BITS) ? COL_BITS : REG_BITS) + 2;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int CFG_IDX_BITS = 2;

  localparam logic [REG_BITS-1:0] WIDTH_RESET  = REG_BITS'(1440);
  localparam logic [REG_BITS-1:0] HEIGHT_RESET = REG_BITS'(720);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // one edge ready for division: col = base + sign * num / den
  typedef struct packed {
    logic signed [COORD_BITS-1:0] base;
    logic                         neg;
    logic [NUM_BITS-1:0]          num;
    logic [COORD_BITS-1:0]        den;
  } edge_t;

  typedef struct packed {
    logic                 hit;
    logic [ROW_BITS-1:0]  row;
    logic [COLR_BITS-1:0] red;
    logic [COLR_BITS-1:0] green;
    logic [COLR_BITS-1:0] blue;
    edge_t                le;
    edge_t                re;
  } item_t;

endpackage

/* rtl/tsp_front.sv */
// front end: vertex sort, edge choice, row test and edge products
// depends on tsp_pkg
module tsp_front (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [tsp_pkg::COORD_BITS-1:0]   vert0_x,
  input  logic signed [tsp_pkg::COORD_BITS-1:0]   vert0_y,
  input  logic signed [tsp_pkg::COORD_BITS-1:0]   vert1_x,
  input  logic signed [tsp_pkg::COORD_BITS-1:0]   vert1_y,
  input  logic signed [tsp_pkg::COORD_BITS-1:0]   vert2_x,
  input  logic signed [tsp_pkg::COORD_BITS-1:0]   vert2_y,
  input  logic [tsp_pkg::COLR_BITS-1:0]           fill_red,
  input  logic [tsp_pkg::COLR_BITS-1:0]           fill_green,
  input  logic [tsp_pkg::COLR_BITS-1:0]           fill_blue,
  input  logic [tsp_pkg::ROW_BITS-1:0]            row_index,
  input  logic [tsp_pkg::REG_BITS-1:0]            image_height,
  output logic                                    push_valid,
  input  logic                                    push_full,
  output tsp_pkg::item_t                          push_item
);

  localparam int C = tsp_pkg::COORD_BITS;
  localparam int D = tsp_pkg::CMP_BITS;

  logic adv;

  // sort stage registers
  logic                a_valid;
  logic signed [C-1:0] a_x [3];
  logic signed [C-1:0] a_y [3];
  logic [tsp_pkg::ROW_BITS-1:0]  a_row;
  logic [tsp_pkg::COLR_BITS-1:0] a_red, a_green, a_blue;

  // edge stage registers
  logic                b_valid;
  logic                b_hit;
  logic [tsp_pkg::ROW_BITS-1:0]  b_row;
  logic [tsp_pkg::COLR_BITS-1:0] b_red, b_green, b_blue;
  logic signed [C-1:0] b_lx, b_rx;
  logic signed [D-1:0] b_ldx, b_ldt, b_lden, b_rdx, b_rdt, b_rden;

  // product stage registers
  logic           c_valid;
  tsp_pkg::item_t c_item;

  assign adv        = !c_valid || !push_full;
  assign in_stall   = !adv;
  assign push_valid = c_valid;
  assign push_item  = c_item;

  // three compare-and-swap steps on row
  logic signed [C-1:0] s_x [3];
  logic signed [C-1:0] s_y [3];
  logic signed [C-1:0] t_x, t_y;
  always_comb begin
    t_x = '0; t_y = '0;
    s_x[0] = vert0_x; s_y[0] = vert0_y;
    s_x[1] = vert1_x; s_y[1] = vert1_y;
    s_x[2] = vert2_x; s_y[2] = vert2_y;
    if (s_y[0] > s_y[1]) begin
      t_x = s_x[0]; t_y = s_y[0];
      s_x[0] = s_x[1]; s_y[0] = s_y[1];
      s_x[1] = t_x; s_y[1] = t_y;
    end
    if (s_y[0] > s_y[2]) begin
      t_x = s_x[0]; t_y = s_y[0];
      s_x[0] = s_x[2]; s_y[0] = s_y[2];
      s_x[2] = t_x; s_y[2] = t_y;
    end
    if (s_y[1] > s_y[2]) begin
      t_x = s_x[1]; t_y = s_y[1];
      s_x[1] = s_x[2]; s_y[1] = s_y[2];
      s_x[2] = t_x; s_y[2] = t_y;
    end
  end

  // edge choice and row test on sorted vertices
  logic signed [D-1:0] y, y0, y1, y2, x0, x1, x2;
  logic                hit_next;
  logic signed [C-1:0] lx_next;
  logic signed [D-1:0] ldx_next, ldt_next, lden_next;
  always_comb begin
    y  = D'(signed'({1'b0, a_row}));
    y0 = D'(a_y[0]); y1 = D'(a_y[1]); y2 = D'(a_y[2]);
    x0 = D'(a_x[0]); x1 = D'(a_x[1]); x2 = D'(a_x[2]);
    hit_next = (y2 != y0) && (y >= y0) && (y <= y2) &&
               ({{(tsp_pkg::REG_BITS - tsp_pkg::ROW_BITS){1'b0}}, a_row} < image_height);
    if (y < y1) begin
      lx_next = a_x[0]; ldx_next = x1 - x0; ldt_next = y - y0; lden_next = y1 - y0;
    end else if (y2 != y1) begin
      lx_next = a_x[1]; ldx_next = x2 - x1; ldt_next = y - y1; lden_next = y2 - y1;
    end else begin
      lx_next = a_x[1]; ldx_next = '0; ldt_next = '0; lden_next = D'(1);
    end
  end

  // products and signs of both edges
  logic [C-1:0] l_mag, r_mag;
  always_comb begin
    l_mag = C'(b_ldx[D-1] ? -b_ldx : b_ldx);
    r_mag = C'(b_rdx[D-1] ? -b_rdx : b_rdx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x     <= s_x;
      a_y     <= s_y;
      a_row   <= row_index;
      a_red   <= fill_red;
      a_green <= fill_green;
      a_blue  <= fill_blue;

      b_hit   <= hit_next;
      b_row   <= a_row;
      b_red   <= a_red;
      b_green <= a_green;
      b_blue  <= a_blue;
      b_lx    <= lx_next;
      b_ldx   <= ldx_next;
      b_ldt   <= ldt_next;
      b_lden  <= lden_next;
      b_rx    <= a_x[0];
      b_rdx   <= x2 - x0;
      b_rdt   <= y - y0;
      b_rden  <= y2 - y0;

      c_item.hit      <= b_hit;
      c_item.row      <= b_row;
      c_item.red      <= b_red;
      c_item.green    <= b_green;
      c_item.blue     <= b_blue;
      c_item.le.base  <= b_lx;
      c_item.le.neg   <= b_ldx[D-1];
      c_item.le.num   <= l_mag * b_ldt[C-1:0];
      c_item.le.den   <= b_lden[C-1:0];
      c_item.re.base  <= b_rx;
      c_item.re.neg   <= b_rdx[D-1];
      c_item.re.num   <= r_mag * b_rdt[C-1:0];
      c_item.re.den   <= b_rden[C-1:0];
    end
  end

endmodule

/* rtl/tsp_queue.sv */
// short queue between front and back end
// depends on tsp_pkg and the assertion macro header
`include "triangle_scanline_span_top_defines.svh"
module tsp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tsp_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tsp_pkg::item_t pop_item
);

  localparam int AW = tsp_pkg::Q_AW;

  tsp_pkg::item_t mem [tsp_pkg::Q_DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [AW:0]    count;
  logic           do_push, do_pop;

  assign full     = (count == (AW+1)'(tsp_pkg::Q_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_item;
  end

  `TSP_ASSERT_NOW(q_count_bound, clk, rst, 1'b1, count <= (AW+1)'(tsp_pkg::Q_DEPTH))
  `TSP_ASSERT_NEXT(q_pop_only, clk, rst, do_pop && !do_push, count == $past(count) - 1'b1)
  `TSP_ASSERT_NOW(q_ptr_track, clk, rst, 1'b1, (wr_ptr - rd_ptr) == count[AW-1:0])

endmodule

/* rtl/tsp_back.sv */
// back end: pipelined edge division, span ordering and clamping, output register
// depends on tsp_pkg and the assertion macro header
`include "triangle_scanline_span_top_defines.svh"
module tsp_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  tsp_pkg::item_t                    q_item,
  output logic                              q_pop,
  input  logic [tsp_pkg::REG_BITS-1:0]      image_width,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              covered,
  output logic [tsp_pkg::ROW_BITS-1:0]      span_row,
  output logic [tsp_pkg::ROW_BITS-1:0]      span_left,
  output logic [tsp_pkg::ROW_BITS-1:0]      span_right,
  output logic [tsp_pkg::COLR_BITS-1:0]     out_red,
  output logic [tsp_pkg::COLR_BITS-1:0]     out_green,
  output logic [tsp_pkg::COLR_BITS-1:0]     out_blue
);

  localparam int C  = tsp_pkg::COORD_BITS;
  localparam int N  = tsp_pkg::NUM_BITS;
  localparam int Q  = tsp_pkg::QUO_BITS;
  localparam int CB = tsp_pkg::COL_BITS;
  localparam int W  = tsp_pkg::WIDE_BITS;

  logic adv;
  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && !q_empty;

  // one restoring step: remainder and quotient bit for shift s
  function automatic logic [N:0] div_step(input logic [N-1:0] rem,
                                          input logic [C-1:0] den,
                                          input int unsigned s);
    logic [N-1:0] sh;
    logic [N:0]   res;
    sh  = N'(den) << s;
    res = {1'b0, rem};
    if (rem >= sh) res = {1'b1, rem - sh};
    return res;
  endfunction

  // division stages, one quotient bit each
  logic           d_valid [Q+1];
  tsp_pkg::item_t d_item  [Q+1];
  logic [Q-1:0]   d_lq    [Q+1];
  logic [Q-1:0]   d_rq    [Q+1];

  assign d_valid[0] = !q_empty;
  assign d_item[0]  = q_item;
  assign d_lq[0]    = '0;
  assign d_rq[0]    = '0;

  for (genvar i = 0; i < Q; i++) begin : g_div
    logic [N:0]     l_st, r_st;
    tsp_pkg::item_t st_item;
    assign l_st = div_step(d_item[i].le.num, d_item[i].le.den, Q-1-i);
    assign r_st = div_step(d_item[i].re.num, d_item[i].re.den, Q-1-i);

    // item passed on with both remainders updated
    always_comb begin
      st_item        = d_item[i];
      st_item.le.num = l_st[N-1:0];
      st_item.re.num = r_st[N-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[i+1] <= 1'b0;
      end else if (adv) begin
        d_valid[i+1] <= d_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_item[i+1] <= st_item;
        d_lq[i+1]   <= d_lq[i] | (Q'(l_st[N]) << (Q-1-i));
        d_rq[i+1]   <= d_rq[i] | (Q'(r_st[N]) << (Q-1-i));
      end
    end
  end

  // edge columns
  logic                 e_valid;
  tsp_pkg::item_t       e_item;
  logic signed [CB-1:0] e_lcol, e_rcol;
  logic signed [CB-1:0] lq_s, rq_s;
  always_comb begin
    lq_s = signed'(CB'(d_lq[Q]));
    rq_s = signed'(CB'(d_rq[Q]));
    if (d_item[Q].le.neg) lq_s = -lq_s;
    if (d_item[Q].re.neg) rq_s = -rq_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid[Q];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_item <= d_item[Q];
      e_lcol <= CB'(signed'(d_item[Q].le.base)) + lq_s;
      e_rcol <= CB'(signed'(d_item[Q].re.base)) + rq_s;
    end
  end

  // order, off-image test and clamp
  logic signed [W-1:0] lo, hi, wmax, wcap;
  logic                vis;
  always_comb begin
    lo = W'(e_lcol);
    hi = W'(e_rcol);
    if (lo > hi) begin
      lo = W'(e_rcol);
      hi = W'(e_lcol);
    end
    wcap = signed'(W'({1'b0, {tsp_pkg::ROW_BITS{1'b1}}}));
    wmax = signed'(W'({1'b0, image_width})) - W'(1);
    vis  = e_item.hit && (hi >= 0) && (lo < signed'(W'({1'b0, image_width})));
    if (wmax > wcap) wmax = wcap;
    if (lo < 0) lo = '0;
    if (hi > wmax) hi = wmax;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      covered    <= vis;
      span_row   <= e_item.row;
      span_left  <= vis ? lo[tsp_pkg::ROW_BITS-1:0] : '0;
      span_right <= vis ? hi[tsp_pkg::ROW_BITS-1:0] : '0;
      out_red    <= vis ? e_item.red   : '0;
      out_green  <= vis ? e_item.green : '0;
      out_blue   <= vis ? e_item.blue  : '0;
    end
  end

  `TSP_ASSERT_NOW(bk_span_order, clk, rst, out_valid && covered, span_left <= span_right)
  `TSP_ASSERT_NOW(bk_blank, clk, rst, out_valid && !covered, span_left == '0 && span_right == '0 && out_red == '0 && out_green == '0 && out_blue == '0)
  `TSP_ASSERT_NEXT(bk_drain, clk, rst, e_valid && adv, out_valid)

endmodule

/* rtl/triangle_scanline_span_top.sv */
// Scanline span of one flat-shaded triangle: top level.
// Input channel: in_valid/in_stall with three signed vertices, a flat colour
// and a row index per beat. Output channel: out_valid/out_stall with one span
// per input beat, in order. Configuration: cfg_valid/cfg_ready writes
// image_width (index 0) and image_height (index 1); cfg_ready is always high.
// Throughput: one beat per cycle in and out while out_stall is low.
// Pipeline: front registers for sort, edge choice and products, the 4-entry
// queue memory, 14 divider stages (one quotient bit each), one column stage
// and the output register.
// The 14-stage restoring divider pair sets the latency; its stages advance
// together, so a stalled output holds the whole back end while the front end
// keeps filling the queue, and in_stall rises only once the queue is full.
// Reset clears every valid and the queue; registers return to 1440 x 720.
// depends on tsp_pkg, tsp_front, tsp_queue, tsp_back
module triangle_scanline_span_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [tsp_pkg::COORD_BITS-1:0] vert0_x,
  input  logic signed [tsp_pkg::COORD_BITS-1:0] vert0_y,
  input  logic signed [tsp_pkg::COORD_BITS-1:0] vert1_x,
  input  logic signed [tsp_pkg::COORD_BITS-1:0] vert1_y,
  input  logic signed [tsp_pkg::COORD_BITS-1:0] vert2_x,
  input  logic signed [tsp_pkg::COORD_BITS-1:0] vert2_y,
  input  logic [tsp_pkg::COLR_BITS-1:0]         fill_red,
  input  logic [tsp_pkg::COLR_BITS-1:0]         fill_green,
  input  logic [tsp_pkg::COLR_BITS-1:0]         fill_blue,
  input  logic [tsp_pkg::ROW_BITS-1:0]          row_index,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  covered,
  output logic [tsp_pkg::ROW_BITS-1:0]          span_row,
  output logic [tsp_pkg::ROW_BITS-1:0]          span_left,
  output logic [tsp_pkg::ROW_BITS-1:0]          span_right,
  output logic [tsp_pkg::COLR_BITS-1:0]         out_red,
  output logic [tsp_pkg::COLR_BITS-1:0]         out_green,
  output logic [tsp_pkg::COLR_BITS-1:0]         out_blue,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tsp_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [tsp_pkg::REG_BITS-1:0]          cfg_data
);

  logic [tsp_pkg::REG_BITS-1:0] image_width, image_height;
  logic           push_valid, q_full, q_empty, q_pop;
  tsp_pkg::item_t push_item, pop_item;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= tsp_pkg::WIDTH_RESET;
      image_height <= tsp_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (tsp_pkg::cfg_reg_t'(cfg_index))
        tsp_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        tsp_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  tsp_front u_front (
    .clk, .rst, .in_valid, .in_stall,
    .vert0_x, .vert0_y, .vert1_x, .vert1_y, .vert2_x, .vert2_y,
    .fill_red, .fill_green, .fill_blue, .row_index,
    .image_height,
    .push_valid, .push_full(q_full), .push_item
  );

  tsp_queue u_queue (
    .clk, .rst,
    .push(push_valid), .push_item, .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_item
  );

  tsp_back u_back (
    .clk, .rst,
    .q_empty, .q_item(pop_item), .q_pop,
    .image_width,
    .out_valid, .out_stall,
    .covered, .span_row, .span_left, .span_right,
    .out_red, .out_green, .out_blue
  );

endmodule
